[rtl/pssr_pkg.sv]
// shared widths, command and register codes and the pixel record for the
// palette stretch span renderer; no dependencies
`default_nettype none

package pssr_pkg;

  localparam int SOURCE_LEN_DEF  = 1024;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int CMD_W           = 3;
  localparam int TIDX_W          = 10;
  localparam int COLOR_W         = 24;
  localparam int POS_W           = 26;
  localparam int COORD_W         = 12;
  localparam int PITCH_W         = 14;
  localparam int COUNT_W         = 13;
  localparam int ADDR_W          = 27;
  localparam int CHAN_W          = 8;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 14;

  localparam int TABLE_DEPTH     = 256;
  localparam int BYTES_PER_PIXEL = 3;
  localparam int GREEN_SHIFT     = 8;
  localparam int BLUE_SHIFT      = 16;

  localparam int QUEUE_DEPTH     = 8;
  localparam int QP_W            = $clog2(QUEUE_DEPTH);

  typedef enum logic [CMD_W-1:0] {
    CMD_PALETTE = 3'd0,
    CMD_REMAP   = 3'd1,
    CMD_SOURCE  = 3'd2,
    CMD_BEGIN   = 3'd3,
    CMD_TICK    = 3'd4
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_PITCH       = 3'd0,
    CFG_USE_REMAP       = 3'd1,
    CFG_KEY_ENABLE      = 3'd2,
    CFG_KEY_INDEX       = 3'd3,
    CFG_PALETTE_PRESENT = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [ADDR_W-1:0] pixel_address;
    logic              write_enable;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              last_of_span;
  } pixel_t;

endpackage

`default_nettype wire

[rtl/pssr_if.sv]
// valid/ready channel interfaces of the span renderer: requests in, pixels
// out, register writes; widths from pssr_pkg
`default_nettype none

interface pssr_in_if;
  logic                              valid;
  logic                              ready;
  logic [pssr_pkg::CMD_W-1:0]        cmd;
  logic [pssr_pkg::TIDX_W-1:0]       table_index;
  logic [pssr_pkg::COLOR_W-1:0]      table_value;
  logic [pssr_pkg::POS_W-1:0]        start_position;
  logic signed [pssr_pkg::POS_W-1:0] position_step;
  logic [pssr_pkg::COORD_W-1:0]      span_left;
  logic [pssr_pkg::COORD_W-1:0]      span_right;
  logic [pssr_pkg::COORD_W-1:0]      span_row;

  modport source (output valid, cmd, table_index, table_value, start_position,
                  position_step, span_left, span_right, span_row, input ready);
  modport sink   (input valid, cmd, table_index, table_value, start_position,
                  position_step, span_left, span_right, span_row, output ready);
endinterface

interface pssr_out_if;
  logic                         valid;
  logic                         ready;
  logic [pssr_pkg::ADDR_W-1:0]  pixel_address;
  logic                         write_enable;
  logic [pssr_pkg::CHAN_W-1:0]  red;
  logic [pssr_pkg::CHAN_W-1:0]  green;
  logic [pssr_pkg::CHAN_W-1:0]  blue;
  logic                         last_of_span;

  modport source (output valid, pixel_address, write_enable, red, green, blue,
                  last_of_span, input ready);
  modport sink   (input valid, pixel_address, write_enable, red, green, blue,
                  last_of_span, output ready);
endinterface

interface pssr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pssr_pkg::CFG_IDX_W-1:0]  addr;
  logic [pssr_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

[rtl/palette_stretch_span_renderer.sv]
// palette stretch span renderer top level: span state, source row, remap and
// palette memories, read pipeline and output queue; uses pssr_pkg, pssr_if
// One pixel request is taken per clock while in.ready is high and one pixel
// leaves per clock while out.ready is high; a tick request passes through
// the pipeline: three stages fold the source position into the row (reciprocal
// multiply, back-multiply, correcting subtract), then one synchronous read each
// of the source row, the remap table and the palette. Table and source writes
// travel down the same pipeline and land in the memory at the stage where that
// memory is read, so every request sees exactly the writes accepted before it.
// Results wait in an 8-entry queue; requests stall only when 8 pixels are in
// flight or queued. Tables hold no reset value and need no clearing pass.
// Registers may be written only while no pixel is in flight.
`default_nettype none

module palette_stretch_span_renderer #(
  parameter int SOURCE_LEN = pssr_pkg::SOURCE_LEN_DEF,
  parameter int FRAC_BITS  = pssr_pkg::FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  pssr_in_if.sink    in,
  pssr_out_if.source out,
  pssr_cfg_if.sink   cfg
);

  localparam int ADDR_W   = pssr_pkg::ADDR_W;
  localparam int POS_W    = pssr_pkg::POS_W;
  localparam int COUNT_W  = pssr_pkg::COUNT_W;
  localparam int TIDX_W   = pssr_pkg::TIDX_W;
  localparam int COLOR_W  = pssr_pkg::COLOR_W;
  localparam int CHAN_W   = pssr_pkg::CHAN_W;
  localparam int QP_W     = pssr_pkg::QP_W;

  localparam int X_W      = POS_W - FRAC_BITS;
  localparam int SIDX_W   = $clog2(SOURCE_LEN);
  localparam int R_W      = SIDX_W + 1;
  localparam int D_W      = (X_W > R_W) ? X_W : R_W;
  localparam int RECIP_S  = X_W + SIDX_W;
  localparam int RC_W     = X_W + 2;
  localparam int P1_W     = X_W + RC_W;
  localparam int P2_W     = X_W + R_W;
  localparam logic [63:0]     RECIP_FULL = (64'd1 << RECIP_S) / SOURCE_LEN;
  localparam logic [RC_W-1:0] RECIP      = RECIP_FULL[RC_W-1:0];
  localparam logic [R_W-1:0]  LEN_R      = R_W'(SOURCE_LEN);
  localparam logic [QP_W:0]   QDEPTH     = (QP_W+1)'(pssr_pkg::QUEUE_DEPTH);

  typedef struct packed {
    logic               tick;
    logic               last;
    logic [ADDR_W-1:0]  addr;
    logic               pal_wr;
    logic               remap_wr;
    logic               src_wr;
    logic [TIDX_W-1:0]  tindex;
    logic [COLOR_W-1:0] tvalue;
  } stage_t;

  // configuration registers
  logic [pssr_pkg::PITCH_W-1:0] row_pitch;
  logic                         use_remap;
  logic                         key_enable;
  logic [CHAN_W-1:0]            key_index;
  logic                         palette_present;

  // span state
  logic [POS_W-1:0]   position;
  logic [POS_W-1:0]   step;
  logic [COUNT_W-1:0] remaining;
  logic [ADDR_W-1:0]  dest_offset;

  // pipeline
  stage_t            ctl [1:6];
  stage_t            ctl_next;
  logic [X_W-1:0]    x1, x2, x3;
  logic [X_W-1:0]    q2, m3;
  logic [P1_W-1:0]   quot_prod;
  logic [D_W-1:0]    diff3;
  logic [R_W-1:0]    r3;
  logic [SIDX_W-1:0] src_addr;
  logic [CHAN_W-1:0] src_rd, remap_rd, raw5;
  logic [CHAN_W-1:0] pal_idx;
  logic [COLOR_W-1:0] pal_rd;
  logic              we6;

  logic [CHAN_W-1:0]  source_row  [SOURCE_LEN];
  logic [CHAN_W-1:0]  remap_table [pssr_pkg::TABLE_DEPTH];
  logic [COLOR_W-1:0] palette     [pssr_pkg::TABLE_DEPTH];

  // output queue
  pssr_pkg::pixel_t queue [pssr_pkg::QUEUE_DEPTH];
  pssr_pkg::pixel_t pixel6;
  logic [QP_W-1:0]  wr_ptr, rd_ptr;
  logic [QP_W:0]    qcount, occ;
  logic             push, pop;

  // request decode
  pssr_pkg::cmd_t    cmd_in;
  logic              accept, tick_go, tbl_ok, src_ok;
  logic [ADDR_W-1:0] row_base, col_off;
  logic [COUNT_W-1:0] span_len;

  // ---------------------------------------------------------------- config
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pitch       <= '0;
      use_remap       <= 1'b0;
      key_enable      <= 1'b0;
      key_index       <= '0;
      palette_present <= 1'b1;
    end else if (cfg.valid) begin
      case (pssr_pkg::cfg_idx_t'(cfg.addr))
        pssr_pkg::CFG_ROW_PITCH:       row_pitch       <= cfg.data;
        pssr_pkg::CFG_USE_REMAP:       use_remap       <= cfg.data[0];
        pssr_pkg::CFG_KEY_ENABLE:      key_enable      <= cfg.data[0];
        pssr_pkg::CFG_KEY_INDEX:       key_index       <= cfg.data[CHAN_W-1:0];
        pssr_pkg::CFG_PALETTE_PRESENT: palette_present <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- accept
  assign in.ready = (occ < QDEPTH);
  assign accept   = in.valid && in.ready;
  assign cmd_in   = pssr_pkg::cmd_t'(in.cmd);
  assign tick_go  = accept && (cmd_in == pssr_pkg::CMD_TICK) && (remaining != '0);
  assign tbl_ok   = in.table_index < TIDX_W'(pssr_pkg::TABLE_DEPTH);
  assign src_ok   = 32'(in.table_index) < 32'(SOURCE_LEN);
  assign row_base = ADDR_W'(in.span_row) * ADDR_W'(row_pitch);
  assign col_off  = ADDR_W'(in.span_left) * ADDR_W'(pssr_pkg::BYTES_PER_PIXEL);
  assign span_len = (in.span_right > in.span_left) ?
                    COUNT_W'(in.span_right - in.span_left) : '0;

  always_comb begin
    ctl_next          = '0;
    ctl_next.tick     = tick_go;
    ctl_next.last     = (remaining == COUNT_W'(1));
    ctl_next.addr     = dest_offset;
    ctl_next.pal_wr   = accept && (cmd_in == pssr_pkg::CMD_PALETTE) && tbl_ok;
    ctl_next.remap_wr = accept && (cmd_in == pssr_pkg::CMD_REMAP) && tbl_ok;
    ctl_next.src_wr   = accept && (cmd_in == pssr_pkg::CMD_SOURCE) && src_ok;
    ctl_next.tindex   = in.table_index;
    ctl_next.tvalue   = in.table_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      step        <= '0;
      remaining   <= '0;
      dest_offset <= '0;
    end else if (accept && (cmd_in == pssr_pkg::CMD_BEGIN)) begin
      // a new span drops whatever was left of the old one
      position    <= in.start_position;
      step        <= $unsigned(in.position_step);
      remaining   <= span_len;
      dest_offset <= row_base + col_off;
    end else if (tick_go) begin
      position    <= position + step;
      remaining   <= remaining - COUNT_W'(1);
      dest_offset <= dest_offset + ADDR_W'(pssr_pkg::BYTES_PER_PIXEL);
    end
  end

  // ---------------------------------------------------------------- pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= 6; k++) ctl[k] <= '0;
    end else begin
      ctl[1] <= ctl_next;
      for (int k = 2; k <= 6; k++) ctl[k] <= ctl[k-1];
    end
  end

  // source index = (position >> FRAC_BITS) mod SOURCE_LEN, quotient estimate
  // is low by at most one so a single correcting subtract finishes it
  assign quot_prod = P1_W'(x1) * P1_W'(RECIP);

  always_ff @(posedge clk) begin
    x1 <= position[POS_W-1:FRAC_BITS];
    x2 <= x1;
    q2 <= X_W'(quot_prod >> RECIP_S);
    x3 <= x2;
    m3 <= X_W'(P2_W'(q2) * P2_W'(SOURCE_LEN));
  end

  assign diff3    = D_W'(x3) - D_W'(m3);
  assign r3       = diff3[R_W-1:0];
  assign src_addr = (r3 >= LEN_R) ? SIDX_W'(r3 - LEN_R) : SIDX_W'(r3);

  // each write lands in the same slot as that memory's read
  always_ff @(posedge clk) begin
    if (ctl[3].src_wr) source_row[SIDX_W'(ctl[3].tindex)] <= ctl[3].tvalue[CHAN_W-1:0];
    src_rd <= source_row[src_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl[4].remap_wr) remap_table[ctl[4].tindex[CHAN_W-1:0]] <= ctl[4].tvalue[CHAN_W-1:0];
    remap_rd <= remap_table[src_rd];
    raw5     <= src_rd;
  end

  assign pal_idx = use_remap ? remap_rd : raw5;

  always_ff @(posedge clk) begin
    if (ctl[5].pal_wr) palette[ctl[5].tindex[CHAN_W-1:0]] <= ctl[5].tvalue;
    pal_rd <= palette[pal_idx];
    we6    <= palette_present && !(key_enable && (raw5 == key_index));
  end

  always_comb begin
    pixel6.pixel_address = ctl[6].addr;
    pixel6.write_enable  = we6;
    pixel6.red           = we6 ? pal_rd[CHAN_W-1:0] : '0;
    pixel6.green         = we6 ? pal_rd[pssr_pkg::GREEN_SHIFT +: CHAN_W] : '0;
    pixel6.blue          = we6 ? pal_rd[pssr_pkg::BLUE_SHIFT +: CHAN_W] : '0;
    pixel6.last_of_span  = ctl[6].last;
  end

  // ---------------------------------------------------------------- queue
  assign push = ctl[6].tick;
  assign pop  = out.valid && out.ready;

  always_ff @(posedge clk) begin
    if (push) queue[wr_ptr] <= pixel6;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      qcount <= '0;
      occ    <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QP_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QP_W'(1);
      qcount <= qcount + (QP_W+1)'(push) - (QP_W+1)'(pop);
      // pixels in flight plus queued; bounds acceptance
      occ    <= occ + (QP_W+1)'(tick_go) - (QP_W+1)'(pop);
    end
  end

  assign out.valid         = (qcount != '0);
  assign out.pixel_address = queue[rd_ptr].pixel_address;
  assign out.write_enable  = queue[rd_ptr].write_enable;
  assign out.red           = queue[rd_ptr].red;
  assign out.green         = queue[rd_ptr].green;
  assign out.blue          = queue[rd_ptr].blue;
  assign out.last_of_span  = queue[rd_ptr].last_of_span;

  // ---------------------------------------------------------------- checks
  a_occ_bound: assert property (@(posedge clk) disable iff (rst) occ <= QDEPTH)
    else $error("pixel occupancy above queue depth");

  a_queue_le_occ: assert property (@(posedge clk) disable iff (rst) qcount <= occ)
    else $error("queue holds more pixels than were counted in");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (qcount < QDEPTH))
    else $error("pixel pushed into a full queue");

endmodule

`default_nettype wire
